>>> design/v3a_pkg.sv
// Shared types, widths, codes and saturation helper for the vector ALU.
package v3a_pkg;

    // Number format and derived widths
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int NUM_W       = DATA_W + FRAC_BITS;
    localparam int ROOT_W      = PROD_W / 2;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = NUM_W;
    localparam int PIPE_DEPTH  = 8 + SQRT_STAGES + DIV_STAGES;
    localparam int IN_W        = 7 * DATA_W;
    localparam int OUT_W       = 4 * DATA_W;

    // Operation codes
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
    localparam logic [OP_W-1:0] OP_SCALE = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
    localparam logic [OP_W-1:0] OP_NEG   = 4'd4;
    localparam logic [OP_W-1:0] OP_DOT   = 4'd5;
    localparam logic [OP_W-1:0] OP_CROSS = 4'd6;
    localparam logic [OP_W-1:0] OP_MAG   = 4'd7;
    localparam logic [OP_W-1:0] OP_NORM  = 4'd8;
    localparam logic [OP_W-1:0] OP_PROJ  = 4'd9;
    localparam logic [OP_W-1:0] OP_REJ   = 4'd10;

    // Status codes
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_DIV0 = 2'd1;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  wide_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam wide_t SAT_HI   = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam wide_t SAT_LO   = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic  ovf;
        word_t val;
    } sat_t;

    // Per-item context that travels beside the arithmetic
    typedef struct packed {
        logic [OP_W-1:0]         op;
        word_t [2:0]             a;
        word_t [2:0]             b;
        word_t                   s;
        logic [2:0][NUM_W-1:0]   num_mag;
        logic [2:0]              num_neg;
        logic [DATA_W-1:0]       dsr_mag;
        logic                    dsr_neg;
        word_t [2:0]             r;
        word_t                   sc;
        logic                    ovf;
        logic                    div0;
    } ctx_t;

    // Clamp a wide signed value into a word and flag when clamped
    function automatic sat_t sat32(input wide_t v);
        sat_t res;
        res.ovf = 1'b1;
        if (v > SAT_HI)
        begin
            res.val = WORD_MAX;
        end
        else if (v < SAT_LO)
        begin
            res.val = WORD_MIN;
        end
        else
        begin
            res.ovf = 1'b0;
            res.val = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> design/vec3_alu.sv
// Top level of the three-component fixed-point vector ALU.
// vec3_alu takes one beat per clock cycle while the output is not held off,
// and returns one result beat for each input beat, in order.
// The path runs through the 32-stage square-root pipeline (two radicand bits
// per stage) followed by three 48-stage dividers (one quotient bit per stage),
// with four stages of multiply and sum ahead and four of scaling and
// saturation behind. Every operation takes the same path, so results keep
// input order. When the output is held off the whole pipeline holds, and
// s_tready follows m_tready or an empty output stage.
module vec3_alu
    import v3a_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scale_value
    input  logic [OP_W-1:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // r_x, r_y, r_z, r_scalar
    output logic [ST_W-1:0]  m_tuser    // status
);

    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;

    word_t in_a [3];
    word_t in_b [3];
    word_t in_s;
    word_t ma_next [6];
    word_t mb_next [6];
    ctx_t  ctx1_next;

    word_t ma1_reg [6];
    word_t mb1_reg [6];
    ctx_t  ctx1_reg;
    prod_t prod2_reg [6];
    ctx_t  ctx2_reg;
    wide_t sum_a3_reg;
    wide_t sum_b3_reg;
    wide_t v3_reg [3];
    ctx_t  ctx3_reg;
    ctx_t  ctx4_next;
    logic [PROD_W-1:0] rad4_next;
    ctx_t  ctx4_reg;
    logic [PROD_W-1:0] rad4_reg;

    ctx_t  ctx_sq_reg [SQRT_STAGES];
    logic [ROOT_W-1:0] root;
    ctx_t  ctx5_next;
    ctx_t  ctx_dv_reg [DIV_STAGES];
    logic [NUM_W-1:0] quo [3];

    ctx_t  ctx_e1_next;
    word_t t_e1_next;
    ctx_t  ctx_e1_reg;
    word_t t_e1_reg;
    prod_t prod_e2_reg [3];
    ctx_t  ctx_e2_reg;
    ctx_t  ctx_e3_next;
    ctx_t  ctx_e3_reg;
    word_t out_r_next [3];
    word_t out_sc_next;
    logic [ST_W-1:0] out_st_next;
    word_t out_r_reg [3];
    word_t out_sc_reg;
    logic [ST_W-1:0] out_st_reg;

    // Advance when the output stage is empty or being taken
    assign adv      = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = {out_sc_reg, out_r_reg[2], out_r_reg[1], out_r_reg[0]};
    assign m_tuser  = out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // Unpack the input beat
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_a[i] = s_tdata[i*DATA_W +: DATA_W];
            in_b[i] = s_tdata[(3+i)*DATA_W +: DATA_W];
        end
        in_s = s_tdata[6*DATA_W +: DATA_W];
    end

    // Steer multiplier operands by operation
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            ma_next[k] = '0;
            mb_next[k] = '0;
        end
        case (s_tuser)
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i] = in_a[i];
                    mb_next[i] = in_s;
                end
            end
            OP_DOT, OP_PROJ, OP_REJ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i]   = in_a[i];
                    mb_next[i]   = in_b[i];
                    ma_next[3+i] = in_b[i];
                    mb_next[3+i] = in_b[i];
                end
            end
            OP_CROSS:
            begin
                ma_next[0] = in_a[1];
                mb_next[0] = in_b[2];
                ma_next[1] = in_a[2];
                mb_next[1] = in_b[1];
                ma_next[2] = in_a[2];
                mb_next[2] = in_b[0];
                ma_next[3] = in_a[0];
                mb_next[3] = in_b[2];
                ma_next[4] = in_a[0];
                mb_next[4] = in_b[1];
                ma_next[5] = in_a[1];
                mb_next[5] = in_b[0];
            end
            OP_MAG, OP_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i] = in_a[i];
                    mb_next[i] = in_a[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ctx1_next    = '0;
        ctx1_next.op = s_tuser;
        for (int i = 0; i < 3; i++)
        begin
            ctx1_next.a[i] = in_a[i];
            ctx1_next.b[i] = in_b[i];
        end
        ctx1_next.s = in_s;
    end

    // Stages 1 to 3: operands, products, sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx1_reg <= ctx1_next;
            for (int k = 0; k < 6; k++)
            begin
                ma1_reg[k]   <= ma_next[k];
                mb1_reg[k]   <= mb_next[k];
                prod2_reg[k] <= ma1_reg[k] * mb1_reg[k];
            end
            ctx2_reg   <= ctx1_reg;
            sum_a3_reg <= SUM_W'(prod2_reg[0]) + SUM_W'(prod2_reg[1])
                        + SUM_W'(prod2_reg[2]);
            sum_b3_reg <= SUM_W'(prod2_reg[3]) + SUM_W'(prod2_reg[4])
                        + SUM_W'(prod2_reg[5]);
            if (ctx2_reg.op == OP_CROSS)
            begin
                v3_reg[0] <= SUM_W'(prod2_reg[0]) - SUM_W'(prod2_reg[1]);
                v3_reg[1] <= SUM_W'(prod2_reg[2]) - SUM_W'(prod2_reg[3]);
                v3_reg[2] <= SUM_W'(prod2_reg[4]) - SUM_W'(prod2_reg[5]);
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v3_reg[i] <= SUM_W'(prod2_reg[i]);
                end
            end
            ctx3_reg <= ctx2_reg;
        end
    end

    // Stage 4: finish the direct operations, set up root and division
    always_comb
    begin
        sat_t sd;
        sat_t sq;
        sat_t sr [3];
        logic [DATA_W-1:0] amag;
        logic [DATA_W-1:0] dmag;
        sd = sat32(sum_a3_reg >>> FRAC_BITS);
        sq = sat32(sum_b3_reg >>> FRAC_BITS);
        for (int i = 0; i < 3; i++)
        begin
            sr[i] = '0;
        end
        ctx4_next         = ctx3_reg;
        ctx4_next.num_mag = '0;
        ctx4_next.num_neg = '0;
        ctx4_next.dsr_mag = '0;
        ctx4_next.dsr_neg = 1'b0;
        ctx4_next.r       = '0;
        ctx4_next.sc      = '0;
        ctx4_next.ovf     = 1'b0;
        ctx4_next.div0    = 1'b0;
        rad4_next         = sum_a3_reg[PROD_W-1:0];
        case (ctx3_reg.op)
            OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    case (ctx3_reg.op)
                        OP_ADD:
                            sr[i] = sat32(SUM_W'($signed(ctx3_reg.a[i]))
                                        + SUM_W'($signed(ctx3_reg.b[i])));
                        OP_SUB:
                            sr[i] = sat32(SUM_W'($signed(ctx3_reg.a[i]))
                                        - SUM_W'($signed(ctx3_reg.b[i])));
                        OP_NEG:
                            sr[i] = sat32(-SUM_W'($signed(ctx3_reg.a[i])));
                        default:
                            sr[i] = sat32(v3_reg[i] >>> FRAC_BITS);
                    endcase
                    ctx4_next.r[i] = sr[i].val;
                end
                ctx4_next.ovf = sr[0].ovf | sr[1].ovf | sr[2].ovf;
            end
            OP_DOT:
            begin
                ctx4_next.sc  = sd.val;
                ctx4_next.ovf = sd.ovf;
            end
            OP_DIV, OP_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    amag = ctx3_reg.a[i][DATA_W-1] ? (~ctx3_reg.a[i] + 1'b1)
                                                   : ctx3_reg.a[i];
                    ctx4_next.num_mag[i] = {amag, {FRAC_BITS{1'b0}}};
                    ctx4_next.num_neg[i] = ctx3_reg.a[i][DATA_W-1];
                end
                if (ctx3_reg.op == OP_DIV)
                begin
                    ctx4_next.dsr_mag = ctx3_reg.s[DATA_W-1] ? (~ctx3_reg.s + 1'b1)
                                                             : ctx3_reg.s;
                    ctx4_next.dsr_neg = ctx3_reg.s[DATA_W-1];
                    ctx4_next.div0    = (ctx3_reg.s == '0);
                end
            end
            OP_PROJ, OP_REJ:
            begin
                dmag = sd.val[DATA_W-1] ? (~sd.val + 1'b1) : sd.val;
                ctx4_next.num_mag[0] = {dmag, {FRAC_BITS{1'b0}}};
                ctx4_next.num_neg[0] = sd.val[DATA_W-1];
                ctx4_next.dsr_mag    = sq.val;
                ctx4_next.ovf        = sd.ovf | sq.ovf;
                ctx4_next.div0       = (sq.val == '0);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx4_reg <= ctx4_next;
            rad4_reg <= rad4_next;
        end
    end

    // Square root, with the context delayed alongside
    v3a_isqrt u_isqrt
    (
        .clk  (clk),
        .en   (adv),
        .rad  (rad4_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                ctx_sq_reg[k] <= (k == 0) ? ctx4_reg : ctx_sq_reg[k-1];
            end
        end
    end

    // Use the root as magnitude or as normalize divisor
    always_comb
    begin
        ctx5_next = ctx_sq_reg[SQRT_STAGES-1];
        if (ctx5_next.op == OP_MAG)
        begin
            ctx5_next.sc  = root[ROOT_W-1] ? WORD_MAX : root;
            ctx5_next.ovf = root[ROOT_W-1];
        end
        else if (ctx5_next.op == OP_NORM)
        begin
            ctx5_next.dsr_mag = root;
            ctx5_next.div0    = (root == '0);
        end
    end

    // Three divider lanes, with the context delayed alongside
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        v3a_div u_div
        (
            .clk (clk),
            .en  (adv),
            .num (ctx5_next.num_mag[g]),
            .dsr (ctx5_next.dsr_mag),
            .quo (quo[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                ctx_dv_reg[k] <= (k == 0) ? ctx5_next : ctx_dv_reg[k-1];
            end
        end
    end

    // Stage E1: sign and clamp the quotients
    always_comb
    begin
        sat_t  qs [3];
        wide_t qw;
        ctx_e1_next = ctx_dv_reg[DIV_STAGES-1];
        t_e1_next   = '0;
        for (int i = 0; i < 3; i++)
        begin
            qw = SUM_W'($signed({1'b0, quo[i]}));
            if (ctx_e1_next.num_neg[i] ^ ctx_e1_next.dsr_neg)
            begin
                qs[i] = sat32(-qw);
            end
            else
            begin
                qs[i] = sat32(qw);
            end
        end
        if (ctx_e1_next.op inside {OP_DIV, OP_NORM})
        begin
            for (int i = 0; i < 3; i++)
            begin
                ctx_e1_next.r[i] = qs[i].val;
            end
            ctx_e1_next.ovf = ctx_e1_next.ovf | qs[0].ovf | qs[1].ovf | qs[2].ovf;
        end
        else if (ctx_e1_next.op inside {OP_PROJ, OP_REJ})
        begin
            t_e1_next       = qs[0].val;
            ctx_e1_next.ovf = ctx_e1_next.ovf | qs[0].ovf;
        end
    end

    // Stage E3: scale b by the projection factor
    always_comb
    begin
        sat_t sp [3];
        ctx_e3_next = ctx_e2_reg;
        for (int i = 0; i < 3; i++)
        begin
            sp[i] = sat32(SUM_W'(prod_e2_reg[i]) >>> FRAC_BITS);
        end
        if (ctx_e3_next.op inside {OP_PROJ, OP_REJ})
        begin
            for (int i = 0; i < 3; i++)
            begin
                ctx_e3_next.r[i] = sp[i].val;
            end
            ctx_e3_next.ovf = ctx_e3_next.ovf | sp[0].ovf | sp[1].ovf | sp[2].ovf;
        end
    end

    // Stage E4: reject difference, zero on divide by zero, pick status
    always_comb
    begin
        sat_t sj [3];
        logic ovf;
        ovf = ctx_e3_reg.ovf;
        for (int i = 0; i < 3; i++)
        begin
            sj[i] = sat32(SUM_W'($signed(ctx_e3_reg.a[i]))
                        - SUM_W'($signed(ctx_e3_reg.r[i])));
            out_r_next[i] = ctx_e3_reg.r[i];
            if (ctx_e3_reg.op == OP_REJ)
            begin
                out_r_next[i] = sj[i].val;
                ovf           = ovf | sj[i].ovf;
            end
        end
        out_sc_next = ctx_e3_reg.sc;
        out_st_next = ovf ? ST_OVF : ST_OK;
        if (ctx_e3_reg.div0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_r_next[i] = '0;
            end
            out_sc_next = '0;
            out_st_next = ST_DIV0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_e1_reg <= ctx_e1_next;
            t_e1_reg   <= t_e1_next;
            for (int i = 0; i < 3; i++)
            begin
                prod_e2_reg[i] <= ctx_e1_reg.b[i] * t_e1_reg;
                out_r_reg[i]   <= out_r_next[i];
            end
            ctx_e2_reg <= ctx_e1_reg;
            ctx_e3_reg <= ctx_e3_next;
            out_sc_reg <= out_sc_next;
            out_st_reg <= out_st_next;
        end
    end

endmodule

>>> design/v3a_isqrt.sv
// Pipelined integer floor square root, two radicand bits per stage.
module v3a_isqrt
    import v3a_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [PROD_W-1:0] rad,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg   [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg  [SQRT_STAGES];
    logic [PROD_W-1:0] rad_reg   [SQRT_STAGES];
    logic [REM_W-1:0]  rem_next  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_next [SQRT_STAGES];
    logic [PROD_W-1:0] rad_next  [SQRT_STAGES];

    // One root bit per stage: try (root*4 + 1) against the shifted remainder
    always_comb
    begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [PROD_W-1:0] rad_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = rad;
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
                rad_in  = rad_reg[k-1];
            end
            rem_sh = {rem_in, rad_in[PROD_W-1 -: 2]};
            trial  = (REM_W+2)'({root_in, 2'b01});
            diff   = rem_sh - trial;
            if (rem_sh >= trial)
            begin
                rem_next[k]  = diff[REM_W-1:0];
                root_next[k] = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh[REM_W-1:0];
                root_next[k] = {root_in[ROOT_W-2:0], 1'b0};
            end
            rad_next[k] = {rad_in[PROD_W-3:0], 2'b00};
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

>>> design/v3a_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module v3a_div
    import v3a_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DATA_W-1:0] dsr,
    output logic [NUM_W-1:0]  quo
);

    logic [DATA_W-1:0] rem_reg  [DIV_STAGES];
    logic [NUM_W-1:0]  nq_reg   [DIV_STAGES];
    logic [DATA_W-1:0] dsr_reg  [DIV_STAGES];
    logic [DATA_W-1:0] rem_next [DIV_STAGES];
    logic [NUM_W-1:0]  nq_next  [DIV_STAGES];
    logic [DATA_W-1:0] dsr_next [DIV_STAGES];

    // Shift a numerator bit into the remainder, subtract when it fits
    always_comb
    begin
        logic [DATA_W-1:0] rem_in;
        logic [NUM_W-1:0]  nq_in;
        logic [DATA_W-1:0] dsr_in;
        logic [DATA_W:0]   rem_sh;
        logic [DATA_W:0]   diff;
        logic              fits;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_in = '0;
                nq_in  = num;
                dsr_in = dsr;
            end
            else
            begin
                rem_in = rem_reg[k-1];
                nq_in  = nq_reg[k-1];
                dsr_in = dsr_reg[k-1];
            end
            rem_sh = {rem_in, nq_in[NUM_W-1]};
            diff   = rem_sh - {1'b0, dsr_in};
            fits   = (rem_sh >= {1'b0, dsr_in});
            rem_next[k] = fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            nq_next[k]  = {nq_in[NUM_W-2:0], fits};
            dsr_next[k] = dsr_in;
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                dsr_reg[k] <= dsr_next[k];
            end
        end
    end

    assign quo = nq_reg[DIV_STAGES-1];

endmodule
